// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC shared definitions
// S-box tables, GF(2^8) helpers and the controller/datapath command type.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int ROUND_KEYS = 15;
   localparam int KEY_WORDS  = 4 * ROUND_KEYS;
   localparam int KW_IDX_W   = $clog2(KEY_WORDS);
   localparam int RND_W      = $clog2(ROUND_KEYS);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_W      = 64;
   localparam logic [7:0] GF_POLY = 8'h1b;

   localparam logic [0:255][7:0] SBOX = {
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [0:255][7:0] INV_SBOX = {
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // controller to datapath commands
   typedef struct packed {
      logic                ks_load;   // load key words 0..7 into window, write word ks_idx
      logic                ks_step;   // compute and write next key word
      logic [KW_IDX_W-1:0] ks_idx;    // key word index being written
      logic                blk_load;  // capture input block, chain-XORed for encrypt
      logic                rnd_step;  // run one cipher round
      logic                rnd_last;  // round without column mix (last encrypt, first decrypt)
      logic                blk_done;  // finish block: chain update, load output
      logic                kw_rd;     // key store read enable
      logic [KW_IDX_W-1:0] kw_addr;   // key store read address
   } dp_cmd_type;

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

// ===== rtl/aes_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/aes_datapath.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC datapath
// Key schedule window, round key store, one shared round unit, chain value.
// ----------------------------------------------------------------------------
module aes_datapath import aes_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  dp_cmd_type     cmd,
   input  logic [255:0]   key,
   input  logic           in_kind,
   input  logic           in_restart,
   input  logic [127:0]   in_block,
   output logic [127:0]   out_block
);

   // schedule window: last 8 key words, w[i-8] in slot 0
   logic [7:0][31:0] win_ff, win_in;
   logic [7:0]       rcon_ff, rcon_in;
   logic [31:0]      ks_word;
   logic             ks_wr;
   logic [KW_IDX_W-1:0] ks_waddr;
   logic [31:0]      rk_word;

   // round state
   logic [127:0] st_ff, st_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] cin_ff, cin_in;       // ciphertext input held for decrypt chain
   logic         dec_ff, dec_in;
   logic [127:0] out_ff, out_in;
   logic [127:0] rkey_ff, rkey_in;    // assembled round key (4 words)
   logic [1:0]   rk_cnt_ff, rk_cnt_in;

   // next key word
   always_comb begin
      logic [31:0] t;
      t = win_ff[7];
      if (cmd.ks_idx[2:0] == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (cmd.ks_idx[2:0] == 3'd4) begin
         t = sub_word(t);
      end
      ks_word = win_ff[0] ^ t;
   end

   always_comb begin
      win_in  = win_ff;
      rcon_in = rcon_ff;
      ks_wr   = 1'b0;
      ks_waddr = cmd.ks_idx;
      if (cmd.ks_load) begin
         win_in  = key;
         for (int i = 0; i < 8; i++) begin
            win_in[i] = key[255 - 32*i -: 32];
         end
         rcon_in = 8'h01;
      end else if (cmd.ks_step) begin
         ks_wr = 1'b1;
         win_in = {ks_word, win_ff[7:1]};
         if (cmd.ks_idx[2:0] == 3'd0) begin
            rcon_in = xtime(rcon_ff);
         end
      end
   end

   // the first 8 words are written straight from the key during the load cycles
   logic       ram_wr;
   logic [KW_IDX_W-1:0] ram_waddr;
   logic [31:0] ram_wdata;

   always_comb begin
      ram_wr    = ks_wr;
      ram_waddr = ks_waddr;
      ram_wdata = ks_word;
      if (cmd.ks_load) begin
         ram_wr    = 1'b1;
         ram_wdata = win_in[cmd.ks_idx[2:0]];
      end
   end

   aes_ram #(.WIDTH(32), .DEPTH(KEY_WORDS)) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.kw_rd),
      .rd_addr (cmd.kw_addr),
      .rd_data (rk_word)
   );

   // collect words read in the previous cycle into the round key
   logic kw_vld_ff;
   always_comb begin
      rkey_in   = rkey_ff;
      rk_cnt_in = rk_cnt_ff;
      if (kw_vld_ff) begin
         rkey_in[127 - 32*rk_cnt_ff -: 32] = rk_word;
         rk_cnt_in = rk_cnt_ff + 2'd1;
      end
   end

   // round unit
   function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] r;
      for (int k = 0; k < 16; k++) b[k] = SBOX[s[127 - 8*k -: 8]];
      for (int c = 0; c < 4; c++)
         for (int rr = 0; rr < 4; rr++) t[4*c + rr] = b[4*((c + rr) % 4) + rr];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[4*c+1] = xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0;
            t[4*c+2] = xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1;
            t[4*c+3] = xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2;
         end
      end
      for (int k = 0; k < 16; k++) r[127 - 8*k -: 8] = t[k];
      return r;
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      gmul = (m[0] ? a : 8'h0) ^ (m[1] ? x2 : 8'h0) ^ (m[2] ? x4 : 8'h0)
           ^ (m[3] ? x8 : 8'h0);
   endfunction

   // inverse round: InvMixColumns (if mix), InvShiftRows, InvSubBytes
   function automatic logic [127:0] inv_round(input logic [127:0] s, input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] r;
      for (int k = 0; k < 16; k++) b[k] = s[127 - 8*k -: 8];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
            b[4*c]   = gmul(a0,4'he) ^ gmul(a1,4'hb) ^ gmul(a2,4'hd) ^ gmul(a3,4'h9);
            b[4*c+1] = gmul(a1,4'he) ^ gmul(a2,4'hb) ^ gmul(a3,4'hd) ^ gmul(a0,4'h9);
            b[4*c+2] = gmul(a2,4'he) ^ gmul(a3,4'hb) ^ gmul(a0,4'hd) ^ gmul(a1,4'h9);
            b[4*c+3] = gmul(a3,4'he) ^ gmul(a0,4'hb) ^ gmul(a1,4'hd) ^ gmul(a2,4'h9);
         end
      end
      for (int c = 0; c < 4; c++)
         for (int rr = 0; rr < 4; rr++) t[4*((c + rr) % 4) + rr] = b[4*c + rr];
      for (int k = 0; k < 16; k++) r[127 - 8*k -: 8] = INV_SBOX[t[k]];
      return r;
   endfunction

   logic [127:0] chain_eff;
   assign chain_eff = in_restart ? 128'h0 : chain_ff;

   always_comb begin
      st_in    = st_ff;
      chain_in = chain_ff;
      cin_in   = cin_ff;
      dec_in   = dec_ff;
      out_in   = out_ff;
      if (cmd.blk_load) begin
         // hold the block (chain-XORed for encrypt); the first key add happens with the round key
         dec_in   = in_kind;
         cin_in   = in_block;
         chain_in = chain_eff;
         st_in    = in_kind ? in_block : (in_block ^ chain_eff);
      end else if (cmd.rnd_step) begin
         // round order: encrypt = key add then round; decrypt = key add then inverse
         if (dec_ff) begin
            st_in = inv_round(st_ff ^ rkey_ff, !cmd.rnd_last);
         end else begin
            st_in = fwd_round(st_ff ^ rkey_ff, !cmd.rnd_last);
         end
      end else if (cmd.blk_done) begin
         if (dec_ff) begin
            out_in   = st_ff ^ rkey_ff ^ chain_ff;
            chain_in = cin_ff;
         end else begin
            out_in   = st_ff ^ rkey_ff;
            chain_in = st_ff ^ rkey_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff    <= '0;
         kw_vld_ff   <= 1'b0;
         rk_cnt_ff   <= '0;
      end else begin
         chain_ff    <= chain_in;
         kw_vld_ff   <= cmd.kw_rd;
         rk_cnt_ff   <= rk_cnt_in;
      end
      win_ff  <= win_in;
      rcon_ff <= rcon_in;
      st_ff   <= st_in;
      cin_ff  <= cin_in;
      dec_ff  <= dec_in;
      out_ff  <= out_in;
      rkey_ff <= rkey_in;
   end

   assign out_block = out_ff;

endmodule

// ===== rtl/aes_ctrl.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC controller
// Sequences key expansion, round key fetch and the round iterations.
// ----------------------------------------------------------------------------
module aes_ctrl import aes_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       keys_stale,
   input  logic       start,
   input  logic       start_dec,
   input  logic       out_free,
   output logic       busy,
   output logic       keys_done,
   output logic       result_done,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_KLOAD, ST_KEXP, ST_FETCH, ST_ROUND, ST_FINISH, ST_WAIT
   } state_type;

   state_type           state_ff;
   logic [KW_IDX_W-1:0] kidx_ff;
   logic [RND_W-1:0]    rnd_ff;    // rounds completed
   logic [2:0]          fcnt_ff;   // fetch step count (key word reads, read latency, settle)
   logic                dec_ff;

   // round key number used at step rnd_ff
   logic [RND_W-1:0] rk_num;
   assign rk_num = dec_ff ? RND_W'(ROUND_KEYS - 1) - rnd_ff : rnd_ff;

   always_comb begin
      cmd = '0;
      cmd.ks_idx = kidx_ff;
      case (state_ff)
         ST_KLOAD: cmd.ks_load = 1'b1;
         ST_KEXP:  cmd.ks_step = 1'b1;
         ST_FETCH: begin
            if (fcnt_ff < 3'd4) begin
               cmd.kw_rd   = 1'b1;
               cmd.kw_addr = KW_IDX_W'({rk_num, fcnt_ff[1:0]});
            end
         end
         ST_ROUND: begin
            if (rnd_ff == RND_W'(ROUND_KEYS - 1)) begin
               cmd.blk_done = 1'b1;
            end else begin
               cmd.rnd_step = 1'b1;
               // encrypt drops the column mix in its last round, decrypt in its first
               cmd.rnd_last = dec_ff ? (rnd_ff == '0)
                                     : (rnd_ff == RND_W'(ROUND_KEYS - 2));
            end
         end
         default: ;
      endcase
      cmd.blk_load = (state_ff == ST_IDLE) && start;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign keys_done   = (state_ff == ST_KEXP) && (kidx_ff == KW_IDX_W'(KEY_WORDS - 1));
   assign result_done = (state_ff == ST_ROUND) && (rnd_ff == RND_W'(ROUND_KEYS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kidx_ff  <= '0;
         rnd_ff   <= '0;
         fcnt_ff  <= '0;
         dec_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  dec_ff  <= start_dec;
                  rnd_ff  <= '0;
                  fcnt_ff <= '0;
                  kidx_ff <= '0;
                  state_ff <= keys_stale ? ST_KLOAD : ST_FETCH;
               end
            end
            ST_KLOAD: begin
               // copy key words 0..7, one per cycle
               kidx_ff <= kidx_ff + KW_IDX_W'(1);
               if (kidx_ff == KW_IDX_W'(7)) begin
                  state_ff <= ST_KEXP;
               end
            end
            ST_KEXP: begin
               kidx_ff <= kidx_ff + KW_IDX_W'(1);
               if (kidx_ff == KW_IDX_W'(KEY_WORDS - 1)) begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               fcnt_ff <= fcnt_ff + 3'd1;
               if (fcnt_ff == 3'd5) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               fcnt_ff <= '0;
               if (rnd_ff == RND_W'(ROUND_KEYS - 1)) begin
                  state_ff <= ST_WAIT;
               end else begin
                  rnd_ff   <= rnd_ff + RND_W'(1);
                  state_ff <= ST_FETCH;
               end
            end
            ST_WAIT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= RND_W'(ROUND_KEYS - 1)) else $error("round count overrun");
   a_done_from_round: assert property (@(posedge clock) disable iff (reset)
      result_done |=> state_ff == ST_WAIT) else $error("finish not followed by wait");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.blk_load |-> !$past(busy) || state_ff == ST_IDLE) else $error("load while busy");

endmodule

// ===== rtl/aes256_cbc_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// AES-256 CBC block cipher top level
// Key registers, input capture and output register around controller/datapath.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// req_     in         tvalid/tready      tdata {block_low, block_high}, tuser {restart, kind}
// rsp_     out        tvalid/tready      tdata {result_low, result_high}
// csr_     in         we only            idx selects key_word_0..3, 64-bit data
//
// One block takes 14 rounds and a final key add on a single shared round unit;
// each step first fetches four key words from the one read port of the round
// key RAM (the reads, the read latency, a settle step, then the round). The
// block takes no new transaction while one is in flight. After reset or a key
// write the first block is preceded by key expansion (eight key words copied,
// then one new word per cycle). Reset is synchronous; the round key RAM needs
// no clear since it is expanded before use. A stalled result holds in the
// output register; the next transaction is taken once that result leaves.
// ----------------------------------------------------------------------------
module aes256_cbc_block_cipher_top import aes_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [127:0]         req_tdata,   // block_high[63:0], block_low[127:64]
   input  logic [1:0]           req_tuser,   // kind[0], restart[1]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [127:0]         rsp_tdata,   // result_high[63:0], result_low[127:64]
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [3:0][63:0] key_ff;
   logic             stale_ff;
   logic             rsp_vld_ff;
   logic             busy, keys_done, result_done;
   dp_cmd_type       cmd;
   logic [127:0]     out_block;
   logic             start;

   // hold the key words; any write marks the schedule stale
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         stale_ff <= 1'b1;
      end else begin
         if (csr_we) begin
            key_ff[csr_idx] <= csr_wdata;
            stale_ff        <= 1'b1;
         end else if (keys_done) begin
            stale_ff <= 1'b0;
         end
      end
   end

   assign req_tready = !busy && !rsp_vld_ff;
   assign start      = req_tvalid && req_tready;

   aes_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .keys_stale  (stale_ff),
      .start       (start),
      .start_dec   (req_tuser[0]),
      .out_free    (1'b1),
      .busy        (busy),
      .keys_done   (keys_done),
      .result_done (result_done),
      .cmd         (cmd)
   );

   aes_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .key        ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .in_kind    (req_tuser[0]),
      .in_restart (req_tuser[1]),
      .in_block   ({req_tdata[63:0], req_tdata[127:64]}),
      .out_block  (out_block)
   );

   // raise the result flag in the cycle after the finishing round
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (result_done) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {out_block[63:0], out_block[127:64]};

endmodule

// ===== test/tb_aes256_cbc_block_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC block cipher testbench
// Drives blocks through the request stream, predicts each result with an
// in-bench AES-256 CBC model, and checks results in order. Covers key
// changes, both directions, chain restarts, random gaps and a long result
// stall that backs up the request side.
// ----------------------------------------------------------------------------
module tb_aes256_cbc_block_cipher_top import aes_pkg::*;;

   localparam int CSR_KEY0 = 0;
   localparam int CSR_KEY1 = 1;
   localparam int CSR_KEY2 = 2;
   localparam int CSR_KEY3 = 3;
   localparam logic DIR_ENC = 1'b0;
   localparam logic DIR_DEC = 1'b1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
   } block_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   aes256_cbc_block_cipher_top dut (.*);

   always #4 clock = ~clock;

   // Predictor state: key registers, expanded schedule and CBC chain
   logic [63:0]  key_reg [4];
   logic [31:0]  sched [60];
   logic         sched_stale;
   block_t       chain;
   logic [7:0]   inv_box [256];
   block_t       expected_results [$];

   int  mismatches = 0;
   int  blocks_sent = 0;
   int  results_seen = 0;
   int  enc_count = 0;
   int  dec_count = 0;
   int  restart_count = 0;
   int  key_loads = 0;
   bit  hold_rsp = 1'b0;
   int  idle_cycles = 0;

   function automatic logic [7:0] gmul2(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   task automatic expand_schedule();
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 8; i++)
         sched[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
      for (int i = 8; i < 60; i++) begin
         t = sched[i-1];
         if (i % 8 == 0) begin
            t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gmul2(rc);
         end else if (i % 8 == 4) begin
            t = subst_word(t);
         end
         sched[i] = sched[i-8] ^ t;
      end
      sched_stale = 1'b0;
   endtask

   // State as 16 bytes, s[4*c+r]; byte 0 is the top of the high half
   typedef logic [7:0] state_t [16];

   function automatic void add_round(ref state_t s, input int rnd);
      for (int k = 0; k < 16; k++)
         s[k] ^= sched[4*rnd + k/4][31 - 8*(k%4) -: 8];
   endfunction

   function automatic void rows_shift(ref state_t s, input bit inv);
      state_t t;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            if (inv) t[4*((c+r)%4) + r] = s[4*c + r];
            else     t[4*c + r] = s[4*((c+r)%4) + r];
         end
      s = t;
   endfunction

   function automatic void cols_mix(ref state_t s);
      logic [7:0] a [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) a[r] = s[4*c + r];
         for (int r = 0; r < 4; r++)
            s[4*c + r] = gmul2(a[r]) ^ gmul2(a[(r+1)%4]) ^ a[(r+1)%4]
                         ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
   endfunction

   function automatic block_t aes_core(input block_t b, input logic dir);
      state_t s;
      block_t o;
      for (int k = 0; k < 8; k++) begin
         s[k]   = b.high[63 - 8*k -: 8];
         s[k+8] = b.low[63 - 8*k -: 8];
      end
      if (dir == DIR_ENC) begin
         add_round(s, 0);
         for (int r = 1; r < 14; r++) begin
            for (int k = 0; k < 16; k++) s[k] = SBOX[s[k]];
            rows_shift(s, 0);
            cols_mix(s);
            add_round(s, r);
         end
         for (int k = 0; k < 16; k++) s[k] = SBOX[s[k]];
         rows_shift(s, 0);
         add_round(s, 14);
      end else begin
         add_round(s, 14);
         rows_shift(s, 1);
         for (int k = 0; k < 16; k++) s[k] = inv_box[s[k]];
         add_round(s, 13);
         for (int r = 13; r > 0; r--) begin
            // inverse column mix is the forward mix three times over
            cols_mix(s); cols_mix(s); cols_mix(s);
            rows_shift(s, 1);
            for (int k = 0; k < 16; k++) s[k] = inv_box[s[k]];
            add_round(s, r - 1);
         end
      end
      for (int k = 0; k < 8; k++) begin
         o.high[63 - 8*k -: 8] = s[k];
         o.low[63 - 8*k -: 8]  = s[k+8];
      end
      return o;
   endfunction

   // Predict one CBC step and advance the chain
   task automatic predict_cbc(input logic dir, input logic restart, input block_t b);
      block_t r;
      if (sched_stale) begin
         expand_schedule();
         key_loads++;
      end
      if (restart) chain = '0;
      if (dir == DIR_ENC) begin
         r = aes_core(b ^ chain, DIR_ENC);
         chain = r;
         enc_count++;
      end else begin
         r = aes_core(b, DIR_DEC) ^ chain;
         chain = b;
         dec_count++;
      end
      if (restart) restart_count++;
      expected_results.push_back(r);
   endtask

   // Send one block: random gap, then hold valid until accepted
   task automatic send_block(input logic dir, input logic restart, input block_t b,
                             input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
      repeat (gap) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tuser  = {restart, dir};
      predict_cbc(dir, restart, b);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      blocks_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic block_t rand_block();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_key(input int idx, input logic [63:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_idx = idx[CSR_IDX_W-1:0];
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      key_reg[idx] = val;
      sched_stale = 1'b1;
   endtask

   task automatic load_key(input logic [63:0] k0, k1, k2, k3);
      wait_drained();
      write_key(CSR_KEY0, k0);
      write_key(CSR_KEY1, k1);
      write_key(CSR_KEY2, k2);
      write_key(CSR_KEY3, k3);
   endtask

   // Result side: random stall per result, checked at the rising edge
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         rsp_tready = 1'b0;
         repeat (stall) @(negedge clock);
         while (hold_rsp) @(negedge clock);
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      block_t exp_b, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result %h", rsp_tdata);
         end else begin
            exp_b = expected_results.pop_front();
            if (got.high !== exp_b.high || got.low !== exp_b.low) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result %0d high exp %h got %h, low exp %h got %h",
                           results_seen, exp_b.high, got.high, exp_b.low, got.low);
            end
         end
      end
   end

   // Watchdog: count cycles with no transaction on either stream
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding",
                  expected_results.size());
         $display("aes256_cbc_block_cipher_top test failed");
         $finish;
      end
   end

   // Directed: FIPS-197 key, both directions, restart, all-zero and all-one data
   task automatic test_directed();
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      send_block(DIR_ENC, 1'b1, {64'h8899aabbccddeeff, 64'h0011223344556677});
      // known ciphertext back to the plaintext from a fresh chain
      send_block(DIR_DEC, 1'b1, {64'heafc49904b496089, 64'h8ea2b7ca516745bf});
      send_block(DIR_ENC, 1'b0, '0);
      send_block(DIR_ENC, 1'b0, '1);
      send_block(DIR_DEC, 1'b0, '0);
      send_block(DIR_DEC, 1'b0, '1);
      send_block(DIR_ENC, 1'b1, '1);
      send_block(DIR_DEC, 1'b1, '1);
      // encrypt a chain of random blocks, restarting on the first
      for (int i = 0; i < 4; i++) send_block(DIR_ENC, i == 0, rand_block());
      load_key('0, '0, '0, '0);
      send_block(DIR_ENC, 1'b1, '0);
      send_block(DIR_DEC, 1'b0, '0);
      load_key('1, '1, '1, '1);
      send_block(DIR_ENC, 1'b1, '1);
      send_block(DIR_DEC, 1'b0, {64'h8000000000000000, 64'h1});
      // change only one key word
      wait_drained();
      write_key(CSR_KEY2, 64'h0123456789abcdef);
      send_block(DIR_ENC, 1'b0, rand_block());
      send_block(DIR_DEC, 1'b1, rand_block());
   endtask

   // Random: mostly continuing chains, occasional restarts and key changes
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 199) == 0)
            load_key({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
         send_block(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, rand_block());
      end
   endtask

   // Back-pressure: freeze the result side while blocks keep coming
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 8; i++)
            send_block(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       rand_block(), 1);
      join
   endtask

   initial begin
      int wait_cycles;
      for (int i = 0; i < 256; i++) inv_box[SBOX[i]] = i[7:0];
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      sched_stale = 1'b1;
      chain = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_random(1720);
      test_backpressure();

      wait_cycles = 0;
      while (expected_results.size() != 0 && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d blocks (%0d encrypt, %0d decrypt, %0d restarts), %0d key loads",
               blocks_sent, enc_count, dec_count, restart_count, key_loads);
      $display("Checked %0d results, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("aes256_cbc_block_cipher_top test passed");
      else
         $display("aes256_cbc_block_cipher_top test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/aes_pkg.sv
rtl/aes_ram.sv
rtl/aes_datapath.sv
rtl/aes_ctrl.sv
rtl/aes256_cbc_block_cipher_top.sv
test/tb_aes256_cbc_block_cipher_top.sv
